// File: src/hpt_pkg.sv
// Package for the heading PI turn controller: widths, constants, register
// indexes, operation codes and the structs shared between the modules.
// No dependencies.
package hpt_pkg;

   // Field and register widths.
   localparam int HEADING_W = 9;
   localparam int TOL_W     = 8;
   localparam int GAIN_W    = 12;
   localparam int DRIVE_W   = 8;
   localparam int POWER_W   = 18;
   localparam int ESUM_W    = 8;
   localparam int ERR_W     = 8;

   // Stream and register port widths.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   // Signed width that holds every angle sum and difference (-511..766).
   localparam int ANG_W  = 11;
   // Product of the proportional gain and an angle, plus headroom for the sum.
   localparam int PROD_W = 24;
   // Integral term: gain times a clamped integral of at most 20.
   localparam int ESUM_MUL_W = 5;
   localparam int INTEG_W    = GAIN_W + ESUM_MUL_W;
   // Fractional bits of the gains and of the power.
   localparam int Q_FRAC = 8;

   // Angle constants.
   localparam logic signed [ANG_W-1:0] ANG_FULL     = ANG_W'(360);
   localparam logic signed [ANG_W-1:0] ANG_HALF     = ANG_W'(180);
   localparam logic signed [ANG_W-1:0] ANG_NEG_HALF = ANG_W'(-180);

   // Power limits in Q.8.
   localparam logic signed [POWER_W-1:0] POWER_LIMIT_Q8 = POWER_W'(2560);
   localparam logic signed [PROD_W-1:0]  POWER_MAX      = PROD_W'(131071);
   localparam logic signed [PROD_W-1:0]  POWER_MIN      = PROD_W'(-131072);

   // Integral clamp and drive limit.
   localparam logic [ESUM_W-1:0]  ESUM_CLAMP_ABOVE = ESUM_W'(20);
   localparam logic [ESUM_W-1:0]  ESUM_CLAMP_TO    = ESUM_W'(19);
   localparam logic [DRIVE_W-1:0] DRIVE_MAX        = DRIVE_W'(127);

   // Register reset values.
   localparam logic [HEADING_W-1:0] TARGET_RESET = HEADING_W'(0);
   localparam logic [TOL_W-1:0]     TOL_RESET    = TOL_W'(3);
   localparam logic [GAIN_W-1:0]    PGAIN_RESET  = GAIN_W'(282);
   localparam logic [GAIN_W-1:0]    IGAIN_RESET  = GAIN_W'(102);

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_TARGET_ANGLE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_TOLERANCE    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN    = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN   = 2'd3;

   // Operation codes.
   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic [HEADING_W-1:0] target_angle;
      logic [TOL_W-1:0]     tolerance;
      logic [GAIN_W-1:0]    prop_gain;
      logic [GAIN_W-1:0]    integ_gain;
   } cfg_type;

   typedef struct packed {
      logic [HEADING_W-1:0]      last_heading;
      logic signed [POWER_W-1:0] last_power;
      logic [ESUM_W-1:0]         error_sum;
      logic                      turning;
   } state_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      done_res;
   } result_type;

endpackage

// File: src/heading_pi_turn_controller_core.sv
// Heading PI turn controller: the input register, the controller state, the
// result register and the configuration registers. Depends on hpt_pkg,
// hpt_csr and hpt_step.
//
// The block takes one transaction per cycle on req_ while rsp_ is not
// stalled and gives exactly one result per transaction on rsp_, through the
// input register and then the result register that drives rsp_tvalid. A
// start transaction (tuser 0) clears the integral, seeds the stored power and
// returns zero drive without done; a heading sample (tuser 1) returns the
// signed drive, or done with zero drive when no turn is armed or once the
// stored heading sits in the tolerance window and the stored power is small.
// The sustained rate is set by the state loop: the stay-running test, the
// proportional multiplier and the saturating add all sit between the input
// register and the state and result registers. Gains are unsigned Q4.8;
// write the registers only while no transaction is in flight.
module heading_pi_turn_controller_core (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hpt_pkg::REQ_DATA_W-1:0]     req_tdata,   // [8:0] heading
   input  logic                               req_tuser,   // [0] operation
   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hpt_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [7:0] drive
   output logic                               rsp_tuser,   // [0] done_res
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hpt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [hpt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hpt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import hpt_pkg::*;

   cfg_type              cfg;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_op_ff, s1_op_in;
   logic [HEADING_W-1:0] s1_heading_ff, s1_heading_in;
   state_type            state_ff, state_in, state_step;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in, step_result;
   logic                 s1_fire, req_fire;

   hpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hpt_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .op        (s1_op_ff),
      .heading   (s1_heading_ff),
      .state_nxt (state_step),
      .result    (step_result)
   );

   // Handshake: the input stage moves on when the result register is free.
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   // Input stage.
   always_comb begin
      s1_valid_in   = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_op_in      = req_fire ? req_tuser : s1_op_ff;
      s1_heading_in = req_fire ? req_tdata[HEADING_W-1:0] : s1_heading_ff;
   end

   // Controller state and result stage.
   always_comb begin
      state_in     = s1_fire ? state_step : state_ff;
      rsp_in       = s1_fire ? step_result : rsp_ff;
      rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff      <= s1_op_in;
      s1_heading_ff <= s1_heading_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.drive;
   assign rsp_tuser  = rsp_ff.done_res;

   // A done result always carries zero drive.
   a_done_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> rsp_ff.drive == '0)
      else $error("done result with nonzero drive");

   // The drive stays within plus and minus 127.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.drive != DRIVE_W'(-128))
      else $error("drive outside the saturation range");

   // A done result leaves the controller idle.
   a_done_clears_turning: assert property (@(posedge clock) disable iff (reset)
      s1_fire && step_result.done_res |=> !state_ff.turning)
      else $error("turning still set after done");

   // A start transaction arms the controller and clears the integral.
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_op_ff == OP_START |=> state_ff.turning && state_ff.error_sum == '0)
      else $error("start did not arm the controller");

   // The controller state moves only when a transaction is processed.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(state_ff))
      else $error("state changed without a transaction");

endmodule

// File: src/hpt_csr.sv
// Configuration registers of the heading PI turn controller behind an
// APB-style port. Depends on hpt_pkg.
module hpt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hpt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hpt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [hpt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output hpt_pkg::cfg_type                  cfg
);
   import hpt_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[REG_IDX_W+1:2];

   // Next register values on a write transaction.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TARGET_ANGLE: cfg_in.target_angle = csr_pwdata[HEADING_W-1:0];
            REG_TOLERANCE:    cfg_in.tolerance    = csr_pwdata[TOL_W-1:0];
            REG_PROP_GAIN:    cfg_in.prop_gain    = csr_pwdata[GAIN_W-1:0];
            REG_INTEG_GAIN:   cfg_in.integ_gain   = csr_pwdata[GAIN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle <= TARGET_RESET;
         cfg_ff.tolerance    <= TOL_RESET;
         cfg_ff.prop_gain    <= PGAIN_RESET;
         cfg_ff.integ_gain   <= IGAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data, zero-extended to the bus width.
   always_comb begin
      case (reg_idx)
         REG_TARGET_ANGLE: csr_prdata = CSR_DATA_W'(cfg_ff.target_angle);
         REG_TOLERANCE:    csr_prdata = CSR_DATA_W'(cfg_ff.tolerance);
         REG_PROP_GAIN:    csr_prdata = CSR_DATA_W'(cfg_ff.prop_gain);
         REG_INTEG_GAIN:   csr_prdata = CSR_DATA_W'(cfg_ff.integ_gain);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: src/hpt_step.sv
// Combinational step of the heading PI turn controller: stay-running test,
// error folding, PI power, direction and drive saturation. Depends on hpt_pkg.
module hpt_step (
   input  hpt_pkg::cfg_type                    cfg,
   input  hpt_pkg::state_type                  state_cur,
   input  logic                                op,
   input  logic [hpt_pkg::HEADING_W-1:0]       heading,
   output hpt_pkg::state_type                  state_nxt,
   output hpt_pkg::result_type                 result
);
   import hpt_pkg::*;

   logic signed [ANG_W-1:0]   tgt, tol, h_cur, h_last;
   logic signed [ANG_W-1:0]   upper_raw, lower_raw, upper, lower;
   logic signed [ANG_W-1:0]   tgt_hi, tgt_lo;
   logic                      wrap_down, wrap_up, outside, keep_running;
   logic signed [ANG_W-1:0]   d0, d1, d2, d3, d4;
   logic [ERR_W-1:0]          err;
   logic [ESUM_W-1:0]         esum_clamped;
   logic signed [ANG_W-1:0]   mul_b;
   logic signed [GAIN_W:0]    pgain_s;
   logic signed [PROD_W-1:0]  prop_prod;
   logic [INTEG_W-1:0]        integ_prod;
   logic signed [PROD_W-1:0]  power;
   logic signed [POWER_W-1:0] power_sat;
   logic [DRIVE_W-1:0]        drive_mag;
   logic                      turn_left;

   assign tgt    = ANG_W'(cfg.target_angle);
   assign tol    = ANG_W'(cfg.tolerance);
   assign h_cur  = ANG_W'(heading);
   assign h_last = ANG_W'(state_cur.last_heading);

   // Tolerance window around the target, wrapped into the circle.
   assign upper_raw = tgt + tol;
   assign lower_raw = tgt - tol;
   assign wrap_down = lower_raw < 0;
   assign wrap_up   = upper_raw > ANG_FULL;
   assign lower     = wrap_down ? lower_raw + ANG_FULL : lower_raw;
   assign upper     = wrap_up ? upper_raw - ANG_FULL : upper_raw;
   assign tgt_hi    = tgt + ANG_HALF;
   assign tgt_lo    = tgt - ANG_HALF;

   // The turn keeps going while the stored heading is outside the window or
   // the stored power is still large.
   assign outside = (wrap_down && ((h_last < lower && h_last > tgt_hi) ||
                                   (h_last > upper && h_last < tgt_hi))) ||
                    (wrap_up && ((h_last > upper && h_last < tgt_lo) ||
                                 (h_last < lower && h_last > tgt_lo))) ||
                    (!wrap_up && !wrap_down && (h_last > upper || h_last < lower));
   assign keep_running = outside || (state_cur.last_power > POWER_LIMIT_Q8);

   // Fold the heading error to 0..180; an error of minus 180 becomes 180.
   assign d0  = h_cur - tgt;
   assign d1  = (d0 > ANG_HALF) ? ANG_FULL - d0 : d0;
   assign d2  = (d1 < ANG_NEG_HALF) ? ANG_FULL + d1 : d1;
   assign d3  = (d2 <= 0 && d2 >= ANG_NEG_HALF) ? -d2 : d2;
   assign d4  = (d3 > ANG_HALF) ? ANG_FULL - d3 : d3;
   assign err = d4[ERR_W-1:0];

   // Integral clamp before use.
   assign esum_clamped = (state_cur.error_sum > ESUM_CLAMP_ABOVE) ?
                         ESUM_CLAMP_TO : state_cur.error_sum;

   // One proportional multiplier serves both the start seed and the sample.
   assign mul_b      = (op == OP_START) ? d0 : ANG_W'(err);
   assign pgain_s    = (GAIN_W+1)'(cfg.prop_gain);
   assign prop_prod  = PROD_W'(pgain_s) * PROD_W'(mul_b);
   assign integ_prod = INTEG_W'(cfg.integ_gain) *
                       INTEG_W'(esum_clamped[ESUM_MUL_W-1:0]);
   assign power      = (op == OP_START) ? prop_prod :
                       prop_prod + PROD_W'(integ_prod);

   // Stored power saturates to the 18-bit signed range.
   always_comb begin
      if (power > POWER_MAX) begin
         power_sat = POWER_MAX[POWER_W-1:0];
      end else if (power < POWER_MIN) begin
         power_sat = POWER_MIN[POWER_W-1:0];
      end else begin
         power_sat = power[POWER_W-1:0];
      end
   end

   // Whole degrees of drive from the non-negative sample power.
   assign drive_mag = (power[PROD_W-1:Q_FRAC+DRIVE_W-1] != '0) ? DRIVE_MAX :
                      DRIVE_W'(power[Q_FRAC+DRIVE_W-2:Q_FRAC]);

   // Direction of the turn.
   assign turn_left = (tgt > h_cur + ANG_HALF) ||
                      (tgt > h_cur - ANG_HALF && h_cur > ANG_HALF && tgt < ANG_HALF) ||
                      (tgt < h_cur && h_cur - tgt < ANG_HALF);

   // Next state and the result of this transaction.
   always_comb begin
      state_nxt       = state_cur;
      result.drive    = '0;
      result.done_res = 1'b0;
      if (op == OP_START) begin
         state_nxt.error_sum    = '0;
         state_nxt.last_heading = heading;
         state_nxt.last_power   = power_sat;
         state_nxt.turning      = 1'b1;
      end else if (!state_cur.turning || !keep_running) begin
         state_nxt.turning = 1'b0;
         result.done_res   = 1'b1;
      end else begin
         state_nxt.last_heading = heading;
         state_nxt.last_power   = power_sat;
         state_nxt.error_sum    = esum_clamped + err;
         result.drive           = turn_left ? -signed'(drive_mag) : signed'(drive_mag);
      end
   end

endmodule
